/* hdl/rsl_pkg.sv */
// ---------------------------------------------------------------------------
// rsl_pkg: shared types and constants for the record store lookup block
// Status and register codes, field widths, controller/datapath structs.
// ---------------------------------------------------------------------------
`default_nettype none

package rsl_pkg;

   localparam int BUFFER_BYTES_DEFAULT = 4096;

   // field widths fixed by the item format
   localparam int ADDR_W   = 12;
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 16;
   localparam int HASH_W   = 32;
   localparam int STATUS_W = 2;
   localparam int OFFSET_W = 13;
   localparam int SIZE_W   = 13;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 13;

   // walk position: below size plus one record length
   localparam int POS_W = 17;

   localparam int HDR_BYTES = 6;
   localparam int HDR_W     = HDR_BYTES * BYTE_W;
   localparam int BIDX_W    = 3;

   localparam logic [SIZE_W-1:0] BUFFER_SIZE_RESET = 13'd4096;

   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_FOUND = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_PLACE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SMALL = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_START_ODD   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_SIZE = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic              write;     // store the request byte
      logic              load;      // latch a lookup request, start at start_odd
      logic [BIDX_W-1:0] rd_idx;    // header byte to read at pos
      logic              capture;   // shift in the byte read last cycle
      logic              advance;   // step to the next record
      logic              set_found; // record matched
      logic              finish;    // register the result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic fits;      // a full header fits before the usable size
      logic len_zero;  // end of chain marker
      logic match;     // length and hash equal the sought record
   } sts_type;

endpackage

`default_nettype wire

/* hdl/rsl_req_if.sv */
// ---------------------------------------------------------------------------
// rsl_req_if: request channel
// Valid/ready channel carrying write and lookup items.
// ---------------------------------------------------------------------------
`default_nettype none

interface rsl_req_if;
   import rsl_pkg::*;

   logic              valid;
   logic              ready;
   logic              kind;
   logic [ADDR_W-1:0] byte_address;
   logic [BYTE_W-1:0] byte_value;
   logic [LEN_W-1:0]  record_length;
   logic [HASH_W-1:0] record_hash;

   modport source (output valid, kind, byte_address, byte_value, record_length,
                   record_hash, input ready);
   modport sink   (input valid, kind, byte_address, byte_value, record_length,
                   record_hash, output ready);
endinterface

`default_nettype wire

/* hdl/rsl_rsp_if.sv */
// ---------------------------------------------------------------------------
// rsl_rsp_if: response channel
// Valid/ready channel carrying lookup results.
// ---------------------------------------------------------------------------
`default_nettype none

interface rsl_rsp_if;
   import rsl_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [OFFSET_W-1:0] offset;

   modport source (output valid, status, offset, input ready);
   modport sink   (input valid, status, offset, output ready);
endinterface

`default_nettype wire

/* hdl/rsl_ram.sv */
// ---------------------------------------------------------------------------
// rsl_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module rsl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* hdl/rsl_ctrl.sv */
// ---------------------------------------------------------------------------
// rsl_ctrl: lookup controller
// Sequences the header reads of the chain walk and the response handshake.
// ---------------------------------------------------------------------------
`default_nettype none

module rsl_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_kind,
   output logic                  req_ready,
   input  wire logic             rsp_ready,
   output logic                  rsp_valid,
   output rsl_pkg::cmd_type      cmd,
   input  wire rsl_pkg::sts_type sts
);
   import rsl_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CHECK  = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_EVAL   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   localparam logic [BIDX_W-1:0] LAST_IDX = BIDX_W'(HDR_BYTES);

   logic [2:0]        state_ff, state_in;
   logic [BIDX_W-1:0] idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      cmd.rd_idx = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_LOOKUP) begin
                  cmd.load = 1'b1;
                  state_in = ST_CHECK;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_CHECK: begin
            idx_in = '0;
            state_in = sts.fits ? ST_READ : ST_FINISH;
         end
         ST_READ: begin
            // read byte idx, capture byte idx-1
            cmd.capture = (idx_ff != '0);
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (sts.len_zero) begin
               state_in = ST_FINISH;
            end else if (sts.match) begin
               cmd.set_found = 1'b1;
               state_in = ST_FINISH;
            end else begin
               cmd.advance = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               cmd.finish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* hdl/rsl_dp.sv */
// ---------------------------------------------------------------------------
// rsl_dp: lookup datapath
// Buffer RAM, configuration registers, walk position, header compare, result.
// ---------------------------------------------------------------------------
`default_nettype none

module rsl_dp #(
   parameter int BUFFER_BYTES = rsl_pkg::BUFFER_BYTES_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [rsl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [rsl_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic [rsl_pkg::ADDR_W-1:0]       req_byte_address,
   input  wire logic [rsl_pkg::BYTE_W-1:0]       req_byte_value,
   input  wire logic [rsl_pkg::LEN_W-1:0]        req_record_length,
   input  wire logic [rsl_pkg::HASH_W-1:0]       req_record_hash,
   input  wire rsl_pkg::cmd_type                 cmd,
   output rsl_pkg::sts_type                      sts,
   output logic      [rsl_pkg::STATUS_W-1:0]     rsp_status,
   output logic      [rsl_pkg::OFFSET_W-1:0]     rsp_offset
);
   import rsl_pkg::*;

   localparam int AW = $clog2(BUFFER_BYTES);
   localparam logic [POS_W-1:0] LIMIT = POS_W'(BUFFER_BYTES);

   logic                start_odd_ff;
   logic [SIZE_W-1:0]   buf_size_ff;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [LEN_W-1:0]    want_ff;
   logic [HASH_W-1:0]   hash_ff;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [HDR_W-1:0]    hdr_ff;
   logic                found_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;

   logic                ram_we;
   logic [AW-1:0]       ram_raddr;
   logic [BYTE_W-1:0]   ram_rdata;
   logic [LEN_W-1:0]    hdr_len;

   logic [SIZE_W-1:0]   off_end, free_end, off_alt, free_alt, off_sel, free_sel;
   logic [SIZE_W-1:0]   restart;

   assign ram_we    = cmd.write && (POS_W'(req_byte_address) < LIMIT);
   assign ram_raddr = pos_ff[AW-1:0] + AW'(cmd.rd_idx);

   rsl_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUFFER_BYTES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (AW'(req_byte_address)),
      .wdata (req_byte_value),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // header bytes: length in the low two, hash bytes above
   assign hdr_len      = hdr_ff[LEN_W-1:0];
   assign sts.fits     = (pos_ff + POS_W'(HDR_BYTES)) <= POS_W'(size_ff);
   assign sts.len_zero = (hdr_len == '0);
   assign sts.match    = (hdr_len == want_ff) && (hdr_ff[HDR_W-1:LEN_W] == hash_ff);

   // clamp the usable size to the memory depth
   assign size_in = (POS_W'(buf_size_ff) > LIMIT) ? SIZE_W'(BUFFER_BYTES) : buf_size_ff;

   always_comb begin
      pos_in = pos_ff;
      if (cmd.load) begin
         pos_in = POS_W'(start_odd_ff);
      end else if (cmd.advance) begin
         pos_in = pos_ff + POS_W'(hdr_len);
      end
   end

   // placement: chain end first, restart position if that lacks room
   always_comb begin
      restart  = SIZE_W'(start_odd_ff);
      off_end  = (pos_ff > POS_W'(size_ff)) ? size_ff : pos_ff[SIZE_W-1:0];
      free_end = size_ff - off_end;
      off_alt  = restart;
      free_alt = (size_ff > restart) ? (size_ff - restart) : '0;
      if (LEN_W'(free_end) < want_ff) begin
         off_sel  = off_alt;
         free_sel = free_alt;
      end else begin
         off_sel  = off_end;
         free_sel = free_end;
      end
      if (found_ff) begin
         status_in = STATUS_FOUND;
         offset_in = pos_ff[OFFSET_W-1:0];
      end else begin
         status_in = (LEN_W'(free_sel) < want_ff) ? STATUS_SMALL : STATUS_PLACE;
         offset_in = off_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_odd_ff <= 1'b0;
         buf_size_ff  <= BUFFER_SIZE_RESET;
         found_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_START_ODD:   start_odd_ff <= csr_wdata[0];
               CSR_BUFFER_SIZE: buf_size_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (cmd.load) begin
            found_ff <= 1'b0;
         end else if (cmd.set_found) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      if (cmd.load) begin
         want_ff <= req_record_length;
         hash_ff <= req_record_hash;
         size_ff <= size_in;
      end
      if (cmd.capture) begin
         hdr_ff <= {ram_rdata, hdr_ff[HDR_W-1:BYTE_W]};
      end
      if (cmd.finish) begin
         status_ff <= status_in;
         offset_ff <= offset_in;
      end
   end

   assign rsp_status = status_ff;
   assign rsp_offset = offset_ff;

endmodule

`default_nettype wire

/* hdl/record_store_lookup_or_place.sv */
// ---------------------------------------------------------------------------
// record_store_lookup_or_place: record buffer lookup and placement
// Stores buffer bytes and walks the record chain to find or place a record.
// ---------------------------------------------------------------------------
//
//   channel   direction  handshake          payload
//   req_chan  in         valid/ready        kind, byte_address, byte_value,
//                                           record_length, record_hash
//   rsp_chan  out        valid/ready        status, offset
//   csr_*     in         csr_we, no wait    csr_index, csr_wdata
//
// A write item is stored while the controller is idle. A lookup item is
// loaded, then each record header walked takes a check, seven read steps
// that fetch the six header bytes through the registered read port, and an
// evaluate; the walk closes with a finish step, preceded by one more check
// when it stops on a header that no longer fits, and the result is valid
// the cycle after finish. The single read port of the buffer RAM, one byte
// per cycle, sets the pace of the walk.
// Reset clears the controller and the configuration registers; buffer RAM
// contents are undefined until written. A result waiting on rsp_chan does
// not block write items; the next lookup holds in its final step until
// the result slot is free.
// ---------------------------------------------------------------------------
`default_nettype none

module record_store_lookup_or_place #(
   parameter int BUFFER_BYTES = rsl_pkg::BUFFER_BYTES_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   rsl_req_if.sink                             req_chan,
   rsl_rsp_if.source                           rsp_chan,
   input  wire logic                           csr_we,
   input  wire logic [rsl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rsl_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rsl_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // controller: walk sequencing and response handshake
   rsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (req_chan.kind),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   // datapath: buffer RAM, walk position, header compare, result register
   rsl_dp #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_byte_address  (req_chan.byte_address),
      .req_byte_value    (req_chan.byte_value),
      .req_record_length (req_chan.record_length),
      .req_record_hash   (req_chan.record_hash),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_status        (rsp_chan.status),
      .rsp_offset        (rsp_chan.offset)
   );

`ifndef SYNTHESIS
   // never overwrite a result that still waits
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("result overwritten while waiting");

   // a finished walk always posts a result
   a_finish_posts: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_chan.valid)
      else $error("finished walk posted no result");

   // no header reads while new items are taken
   a_walk_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.capture || cmd.advance) |-> !req_chan.ready)
      else $error("walk active while accepting items");

   // only defined status codes leave the block
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.status == STATUS_FOUND ||
                          rsp_chan.status == STATUS_PLACE ||
                          rsp_chan.status == STATUS_SMALL))
      else $error("undefined status code");
`endif

endmodule

`default_nettype wire
